/* rtl/lfb_pkg.sv */
// Package: layer count, memory geometry, item types and decode record.
`timescale 1ns / 1ps
`default_nettype none
package lfb_pkg;

  localparam int NUM_LAYERS   = 4;
  localparam int ROW_BANKS    = 8;
  localparam int COL_PARITIES = 2;
  localparam int NUM_RAMS     = ROW_BANKS * COL_PARITIES;
  // per RAM: 8 rows of a layer, 8 byte columns of one parity
  localparam int BANK_DEPTH   = NUM_LAYERS * 64;
  localparam int BANK_AW      = $clog2(BANK_DEPTH);
  localparam int READ_ROW_MAX = 56;
  localparam int ROWS         = 64;
  localparam int ROW_BYTES    = 16;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [1:0] layer;
    logic [7:0] x_pos;
    logic [6:0] y_pos;
    logic       invert;
    logic [7:0] pixel_bits;
    logic [3:0] bit_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0] row_byte_0;
    logic [7:0] row_byte_1;
    logic [7:0] row_byte_2;
    logic [7:0] row_byte_3;
    logic [7:0] row_byte_4;
    logic [7:0] row_byte_5;
    logic [7:0] row_byte_6;
    logic [7:0] row_byte_7;
    logic       read_valid;
    logic       display_touched;
  } out_item_t;

  typedef struct packed {
    logic                              wr_ok;
    logic                              wr_second;
    logic                              rd_ok;
    logic                              par;
    logic [2:0]                        ylo;
    logic [15:0]                       mask;
    logic [15:0]                       bits;
    logic [NUM_RAMS-1:0][BANK_AW-1:0]  addr;
  } dec_t;

endpackage
`default_nettype wire

/* rtl/layered_framebuffer_bit_writer.sv */
// Top level: layered one-bit framebuffer with bit writes and byte-column reads.
`timescale 1ns / 1ps
`default_nettype none
//
// Channel   Direction  Handshake              Payload
// --------  ---------  ---------------------  ------------------------------
// item      in         start && !busy         lfb_pkg::in_item_t
// result    out        done (one cycle)       lfb_pkg::out_item_t
// config    in         cfg_we                 cfg_data = displayed_layer
//
// Each transaction: the accept edge issues the reads of all 16
// banks (8 row banks x 2 column parities), the next edge merges and writes
// back up to two bytes and registers the result, raising done with it; the
// next transaction can already be accepted while done is high.
// Reset starts a clearing pass over all NUM_LAYERS*64 entries of each bank (256
// for four layers), one entry per bank per cycle, with busy high throughout.
// The receiver cannot stall; results are never held.
//
module layered_framebuffer_bit_writer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire lfb_pkg::in_item_t  item,
  output logic                    done,
  output lfb_pkg::out_item_t      result,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_data
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_ACCESS = 2'd2;

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  logic [lfb_pkg::BANK_AW-1:0] clr_addr;
  logic [1:0]                  displayed_layer;
  logic                        touched;     // write to the shown layer
  lfb_pkg::dec_t               dec;
  lfb_pkg::dec_t               dec_q;
  logic                        accept;

  logic [lfb_pkg::ROW_BANKS-1:0][lfb_pkg::COL_PARITIES-1:0][7:0] rd_data;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  lfb_decode u_decode (
    .item (item),
    .dec  (dec)
  );

  // control
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == lfb_pkg::BANK_AW'(lfb_pkg::BANK_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_ACCESS;
        end
      end
      ST_ACCESS: state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr_addr        <= '0;
      displayed_layer <= 2'd0;
      done            <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + lfb_pkg::BANK_AW'(1);
      end
      if (cfg_we) begin
        displayed_layer <= cfg_data;
      end
      done <= (state == ST_ACCESS);
    end
  end

  // transaction payload held for the write-back cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      dec_q   <= dec;
      touched <= (item.kind == lfb_pkg::KIND_WRITE) && (item.layer == displayed_layer);
    end
  end

  // banks: index b*2+q, row bank b, column parity q
  for (genvar b = 0; b < lfb_pkg::ROW_BANKS; b++) begin : g_row
    for (genvar q = 0; q < lfb_pkg::COL_PARITIES; q++) begin : g_par
      localparam int K = b * lfb_pkg::COL_PARITIES + q;
      logic [lfb_pkg::BANK_AW-1:0] addr;
      logic                        we;
      logic [7:0]                  wdata;
      logic                        first;   // holds the byte at the start column
      logic [7:0]                  m;
      logic [7:0]                  d;

      assign first = (1'(q) == dec_q.par);
      assign m     = first ? dec_q.mask[15:8] : dec_q.mask[7:0];
      assign d     = first ? dec_q.bits[15:8] : dec_q.bits[7:0];

      always_comb begin
        addr  = dec_q.addr[K];
        we    = 1'b0;
        wdata = (rd_data[b][q] & ~m) | (d & m);
        unique case (state)
          ST_CLEAR: begin
            addr  = clr_addr;
            we    = 1'b1;
            wdata = 8'h00;
          end
          ST_IDLE:   addr = dec.addr[K];
          ST_ACCESS: we = dec_q.wr_ok && (dec_q.ylo == 3'(b))
                          && (first || dec_q.wr_second);
          default:   we = 1'b0;
        endcase
      end

      lfb_ram #(
        .DEPTH (lfb_pkg::BANK_DEPTH),
        .WIDTH (8)
      ) u_ram (
        .clk   (clk),
        .addr  (addr),
        .we    (we),
        .wdata (wdata),
        .rdata (rd_data[b][q])
      );
    end
  end

  // result register: row i of the column comes from bank (y + i) mod 8
  always_ff @(posedge clk) begin
    logic [7:0] rb [8];
    if (state == ST_ACCESS) begin
      for (int i = 0; i < 8; i++) begin
        rb[i] = dec_q.rd_ok ? rd_data[3'(dec_q.ylo + 3'(i))][dec_q.par] : 8'h00;
      end
      result.row_byte_0      <= rb[0];
      result.row_byte_1      <= rb[1];
      result.row_byte_2      <= rb[2];
      result.row_byte_3      <= rb[3];
      result.row_byte_4      <= rb[4];
      result.row_byte_5      <= rb[5];
      result.row_byte_6      <= rb[6];
      result.row_byte_7      <= rb[7];
      result.read_valid      <= dec_q.rd_ok;
      result.display_touched <= touched;
    end
  end

endmodule
`default_nettype wire

/* rtl/lfb_ram.sv */
// Generic single-port RAM, registered read, read-before-write.
`timescale 1ns / 1ps
`default_nettype none
module lfb_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic [AW-1:0]    addr,
  input  wire logic             we,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

/* rtl/lfb_decode.sv */
// Item decode: range checks, bit mask and data alignment, per-RAM addresses.
`timescale 1ns / 1ps
`default_nettype none
module lfb_decode (
  input  wire lfb_pkg::in_item_t item,
  output lfb_pkg::dec_t          dec
);

  logic [3:0] col;
  logic [3:0] col1;
  logic [2:0] off;
  logic [3:0] cnt;
  logic [3:0] sh;
  logic [7:0] lmask;
  logic [7:0] lbits;
  logic       layer_ok;
  logic [15:0] mask16;
  logic [15:0] bits16;

  assign col      = item.x_pos[6:3];
  assign col1     = col + 4'd1;
  assign off      = item.x_pos[2:0];
  assign layer_ok = int'(item.layer) < lfb_pkg::NUM_LAYERS;
  assign cnt      = (item.bit_count > 4'd8) ? 4'd8 : item.bit_count;
  assign sh       = 4'd8 - cnt;
  // left-aligned mask and data; empty when the count is zero
  assign lmask    = 8'(8'hff << sh);
  assign lbits    = 8'(item.pixel_bits << sh);
  assign mask16   = {lmask, 8'h00} >> off;
  assign bits16   = ({lbits, 8'h00} >> off) ^ (item.invert ? mask16 : 16'h0000);

  always_comb begin
    logic [6:0] row;
    logic [2:0] colhi;
    dec.wr_ok     = (item.kind == lfb_pkg::KIND_WRITE) && layer_ok && !item.x_pos[7]
                    && (int'(item.y_pos) < lfb_pkg::ROWS);
    dec.wr_second = (mask16[7:0] != 8'h00) && (int'(col) < lfb_pkg::ROW_BYTES - 1);
    dec.rd_ok     = (item.kind == lfb_pkg::KIND_READ) && layer_ok && !item.x_pos[7]
                    && (int'(item.y_pos) <= lfb_pkg::READ_ROW_MAX);
    dec.par       = col[0];
    dec.ylo       = item.y_pos[2:0];
    dec.mask      = mask16;
    dec.bits      = bits16;
    for (int b = 0; b < lfb_pkg::ROW_BANKS; b++) begin
      // row in [y, y+7] that lives in bank b
      row = item.y_pos + 7'(3'(3'(b) - item.y_pos[2:0]));
      for (int q = 0; q < lfb_pkg::COL_PARITIES; q++) begin
        colhi = (1'(q) == col[0]) ? col[3:1] : col1[3:1];
        dec.addr[b * lfb_pkg::COL_PARITIES + q] =
          lfb_pkg::BANK_AW'({item.layer, row[5:3], colhi});
      end
    end
  end

endmodule
`default_nettype wire
